>>> src/aaf_pkg.sv
// types and constants shared by the accumulator alu blocks
// no dependencies
`default_nettype none

package aaf_pkg;

    localparam int KIND_W    = 4;
    localparam int OPERAND_W = 20;
    localparam int SHIFT_W   = 7;
    localparam int ACC_W     = 20;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 4'd0,
        KIND_NAND  = 4'd1,
        KIND_ADD   = 4'd2,
        KIND_AND   = 4'd3,
        KIND_OR    = 4'd4,
        KIND_XOR   = 4'd5,
        KIND_NOT   = 4'd6,
        KIND_NEG   = 4'd7,
        KIND_SUB   = 4'd8,
        KIND_SHIFT = 4'd9,
        KIND_MUL   = 4'd10
    } kind_t;

    typedef struct packed {
        logic z;
        logic c;
        logic o;
        logic n;
    } flags_t;

endpackage

`default_nettype wire

>>> src/aaf_cmd_if.sv
// command channel: operation code, operand word and shift distance
// depends on aaf_pkg
`default_nettype none

interface aaf_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [aaf_pkg::KIND_W-1:0]            kind;
    logic signed [aaf_pkg::OPERAND_W-1:0]  operand;
    logic signed [aaf_pkg::SHIFT_W-1:0]    shift_amount;

    modport source (output valid, kind, operand, shift_amount, input ready);
    modport sink   (input valid, kind, operand, shift_amount, output ready);
endinterface

`default_nettype wire

>>> src/aaf_res_if.sv
// result channel: accumulator value and the four flags
// depends on aaf_pkg
`default_nettype none

interface aaf_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [aaf_pkg::ACC_W-1:0]  acc_value;
    logic                              zero_flag;
    logic                              carry_flag;
    logic                              overflow_flag;
    logic                              negative_flag;

    modport source (output valid, acc_value, zero_flag, carry_flag, overflow_flag,
                    negative_flag, input ready);
    modport sink   (input valid, acc_value, zero_flag, carry_flag, overflow_flag,
                    negative_flag, output ready);
endinterface

`default_nettype wire

>>> src/aaf_exec.sv
// combinational execute stage: adder, logic unit, barrel shifter, multiplier, flags
// depends on aaf_pkg
`default_nettype none

module aaf_exec #(
    parameter int WIDTH = 20
) (
    input  wire logic [WIDTH-1:0]                      acc,
    input  wire aaf_pkg::flags_t                       flags,
    input  wire logic [aaf_pkg::KIND_W-1:0]            kind,
    input  wire logic signed [aaf_pkg::OPERAND_W-1:0]  operand,
    input  wire logic signed [aaf_pkg::SHIFT_W-1:0]    shift_amount,
    output logic [WIDTH-1:0]                           acc_next,
    output aaf_pkg::flags_t                            flags_next,
    output logic [aaf_pkg::ACC_W-1:0]                  acc_view
);

    localparam int SW = aaf_pkg::SHIFT_W;

    aaf_pkg::kind_t   op;
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] add_x;
    logic [WIDTH-1:0] add_y;
    logic             add_cin;
    logic [WIDTH:0]   sum;
    logic             add_ovf;
    logic [SW-1:0]    sh_u;
    logic [SW-1:0]    rmag;
    logic [SW-2:0]    lamt;
    logic             sh_left;
    logic             sh_right;
    logic [WIDTH-1:0] lsh_v;
    logic [WIDTH-1:0] lsh_r;
    logic [WIDTH-1:0] rsh_r;
    logic [WIDTH-1:0] prod;
    logic             known;

    assign op = aaf_pkg::kind_t'(kind);

    // operand word brought to accumulator width
    if (WIDTH > aaf_pkg::OPERAND_W) begin : g_op_ext
        assign b = {{(WIDTH-aaf_pkg::OPERAND_W){operand[aaf_pkg::OPERAND_W-1]}}, operand};
    end else begin : g_op_trunc
        assign b = operand[WIDTH-1:0];
    end

    // one shared adder for add, negate (~a + 1) and subtract (a + ~b + 1)
    always_comb
    begin
        add_x   = acc;
        add_y   = b;
        add_cin = 1'b0;
        case (op)
            aaf_pkg::KIND_NEG:
            begin
                add_x   = ~acc;
                add_y   = '0;
                add_cin = 1'b1;
            end
            aaf_pkg::KIND_SUB:
            begin
                add_y   = ~b;
                add_cin = 1'b1;
            end
            default:
            begin
                add_x   = acc;
            end
        endcase
    end

    assign sum     = {1'b0, add_x} + {1'b0, add_y} + {{WIDTH{1'b0}}, add_cin};
    assign add_ovf = (add_x[WIDTH-1] == add_y[WIDTH-1]) && (sum[WIDTH-1] != add_x[WIDTH-1]);

    // barrel shifter; distances of WIDTH or more shift everything out
    assign sh_u     = shift_amount;
    assign sh_left  = !sh_u[SW-1] && (sh_u != '0);
    assign sh_right = sh_u[SW-1];
    assign lamt     = sh_u[SW-2:0] - 1'b1;
    assign rmag     = (~sh_u) + 1'b1;
    assign lsh_v    = acc << lamt;
    assign lsh_r    = lsh_v << 1;
    assign rsh_r    = acc >> rmag;

    // only the low WIDTH bits of the product are kept
    assign prod = acc * b;

    always_comb
    begin
        acc_next   = acc;
        flags_next = flags;
        known      = 1'b1;
        case (op) inside
            aaf_pkg::KIND_LOAD:  acc_next = b;
            aaf_pkg::KIND_NAND:  acc_next = ~(acc & b);
            aaf_pkg::KIND_AND:   acc_next = acc & b;
            aaf_pkg::KIND_OR:    acc_next = acc | b;
            aaf_pkg::KIND_XOR:   acc_next = acc ^ b;
            aaf_pkg::KIND_NOT:   acc_next = ~acc;
            aaf_pkg::KIND_MUL:   acc_next = prod;
            aaf_pkg::KIND_ADD, aaf_pkg::KIND_NEG, aaf_pkg::KIND_SUB:
            begin
                acc_next     = sum[WIDTH-1:0];
                flags_next.c = sum[WIDTH];
                flags_next.o = add_ovf;
            end
            aaf_pkg::KIND_SHIFT:
            begin
                if (sh_left)
                begin
                    acc_next     = lsh_r;
                    flags_next.c = lsh_v[WIDTH-1];
                    flags_next.o = lsh_v[WIDTH-1] ^ lsh_r[WIDTH-1];
                end
                else if (sh_right)
                begin
                    acc_next = rsh_r;
                end
            end
            default:
            begin
                known = 1'b0;
            end
        endcase

        // load and the or/xor/mul group drop carry and overflow
        case (op) inside
            aaf_pkg::KIND_LOAD, aaf_pkg::KIND_OR, aaf_pkg::KIND_XOR, aaf_pkg::KIND_MUL:
            begin
                flags_next.c = 1'b0;
                flags_next.o = 1'b0;
            end
            default:
            begin
                flags_next.z = flags_next.z;
            end
        endcase

        if (known)
        begin
            flags_next.z = (acc_next == '0);
            flags_next.n = acc_next[WIDTH-1];
        end
    end

    // view on the result field, zero filled when the accumulator is narrower
    if (WIDTH >= aaf_pkg::ACC_W) begin : g_view_trunc
        assign acc_view = acc_next[aaf_pkg::ACC_W-1:0];
    end else begin : g_view_ext
        assign acc_view = {{(aaf_pkg::ACC_W-WIDTH){1'b0}}, acc_next};
    end

endmodule

`default_nettype wire

>>> src/accumulator_alu_with_flags.sv
// accumulator alu top level: command register, execute stage, result register
// depends on aaf_pkg, aaf_cmd_if, aaf_res_if, aaf_exec
//
// usage
//   cmd carries one operation per transfer: kind (load, nand, add, and, or, xor,
//   not, negate, subtract, shift, multiply), a 20-bit operand and a signed shift
//   distance. res returns, for every command, the new accumulator and the
//   Z, C, O and N flags. codes 11 to 15 leave everything unchanged and report it.
//   from a cmd transfer to res valid, the command is first registered in the
//   command stage, then executed in one pass through the adder, barrel
//   shifter and multiplier, and the accumulator and result register load
//   together. throughput is one command per cycle while res is not stalled;
//   the accumulator feedback loop runs through the combinational execute stage.
//   the result register parts the two sides: a command is taken while a
//   result waits, and only when both the command stage and the result register
//   are full and res is stalled does cmd.ready drop. nothing is dropped or
//   repeated under any pattern of stalls.
//   reset (rst_n low, asynchronous) clears the accumulator, sets Z, clears
//   C, O and N, and empties both stages.
`default_nettype none

module accumulator_alu_with_flags #(
    parameter int WIDTH = 20
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    aaf_cmd_if.sink     cmd,
    aaf_res_if.source   res
);

    // command stage
    logic                                  s1_valid_reg;
    logic                                  s1_valid_next;
    logic [aaf_pkg::KIND_W-1:0]            s1_kind_reg;
    logic signed [aaf_pkg::OPERAND_W-1:0]  s1_operand_reg;
    logic signed [aaf_pkg::SHIFT_W-1:0]    s1_shift_reg;

    // architectural state
    logic [WIDTH-1:0]                      acc_reg;
    logic [WIDTH-1:0]                      acc_next;
    aaf_pkg::flags_t                       flag_reg;
    aaf_pkg::flags_t                       flag_next;

    // result register
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic [aaf_pkg::ACC_W-1:0]             res_acc_reg;
    logic [aaf_pkg::ACC_W-1:0]             res_acc_next;
    aaf_pkg::flags_t                       res_flags_reg;

    logic                                  out_free;
    logic                                  s1_fire;
    logic                                  cmd_fire;

    // handshake: the result register frees when empty or being taken
    assign out_free  = !out_valid_reg || res.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign cmd.ready = !s1_valid_reg || out_free;
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign s1_valid_next  = cmd_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_fire ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);

    aaf_exec #(
        .WIDTH (WIDTH)
    ) u_exec (
        .acc          (acc_reg),
        .flags        (flag_reg),
        .kind         (s1_kind_reg),
        .operand      (s1_operand_reg),
        .shift_amount (s1_shift_reg),
        .acc_next     (acc_next),
        .flags_next   (flag_next),
        .acc_view     (res_acc_next)
    );

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            flag_reg      <= '{z: 1'b1, c: 1'b0, o: 1'b0, n: 1'b0};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                acc_reg  <= acc_next;
                flag_reg <= flag_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_kind_reg    <= cmd.kind;
            s1_operand_reg <= cmd.operand;
            s1_shift_reg   <= cmd.shift_amount;
        end
        if (s1_fire)
        begin
            res_acc_reg   <= res_acc_next;
            res_flags_reg <= flag_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.acc_value     = res_acc_reg;
    assign res.zero_flag     = res_flags_reg.z;
    assign res.carry_flag    = res_flags_reg.c;
    assign res.overflow_flag = res_flags_reg.o;
    assign res.negative_flag = res_flags_reg.n;

    // Z and N always agree with the accumulator they describe
    a_zn_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (flag_reg.z == (acc_reg == '0)) && (flag_reg.n == acc_reg[WIDTH-1]))
        else $error("Z or N flag disagrees with accumulator");

    // state moves only when a command executes
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(acc_reg) && $stable(flag_reg))
        else $error("accumulator changed without an executed command");

    // an executed command always lands in the result register
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg && (res_flags_reg == flag_reg))
        else $error("executed command did not produce a result");

    // a blocked command stage keeps its command
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_kind_reg)
            && $stable(s1_operand_reg) && $stable(s1_shift_reg))
        else $error("stalled command stage lost its command");

endmodule

`default_nettype wire
